### hdl/bsfe_pkg.sv
`default_nettype none

package bsfe_pkg;

  // Line-level byte codes
  localparam logic [7:0] SYNC_BYTE    = 8'hA5;
  localparam logic [7:0] SYNC_ESC     = 8'hA6;
  localparam logic [7:0] TRAIL_BYTE   = 8'h5A;
  localparam logic [7:0] TRAIL_ESC    = 8'h5B;
  localparam logic [7:0] CODE_LITERAL = 8'h02;
  localparam logic [7:0] CODE_PREFIX  = 8'h01;

  // Reflected CRC-16/ARC polynomial
  localparam logic [15:0] CRC_POLY_REF = 16'hA001;

  // Command queue between the front and the back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // One classified input byte as handed to the back
  typedef struct packed {
    logic [7:0]  data;
    logic        preamble;
    logic        last;
    logic [15:0] crc;
  } cmd_t;

  // Stuffing decision for one raw byte
  typedef struct packed {
    logic       special;
    logic [7:0] first;
    logic [7:0] code;
  } stuff_t;

  // Back sequencer phases
  typedef enum logic [3:0] {
    ST_DATA   = 4'b0001,
    ST_CRC_LO = 4'b0010,
    ST_CRC_HI = 4'b0100,
    ST_TRAIL  = 4'b1000
  } phase_t;

  // One byte of the CRC, one bit a step
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY_REF;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // Escape rule for the sync and trailer bytes and their escape bytes
  function automatic stuff_t stuff_byte(input logic [7:0] b);
    stuff_t s;
    s.special = 1'b1;
    s.first   = b;
    s.code    = CODE_LITERAL;
    unique case (b)
      SYNC_BYTE: begin
        s.first = SYNC_ESC;
        s.code  = CODE_LITERAL;
      end
      SYNC_ESC: begin
        s.first = SYNC_ESC;
        s.code  = CODE_PREFIX;
      end
      TRAIL_BYTE: begin
        s.first = TRAIL_ESC;
        s.code  = CODE_LITERAL;
      end
      TRAIL_ESC: begin
        s.first = TRAIL_ESC;
        s.code  = CODE_PREFIX;
      end
      default: begin
        s.special = 1'b0;
      end
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

### hdl/bsfe_front.sv
`default_nettype none

module bsfe_front
  import bsfe_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_fire,
  input  wire logic [7:0] in_data,
  input  wire logic       in_last,
  output cmd_t            cmd
);

  logic        frame_open;
  logic [15:0] running_crc;
  logic [15:0] crc_new;

  // A closed frame restarts the CRC from zero
  assign crc_new = crc_update(frame_open ? running_crc : 16'h0000, in_data);

  // Classified command for the queue
  always_comb begin
    cmd.data     = in_data;
    cmd.preamble = ~frame_open;
    cmd.last     = in_last;
    cmd.crc      = crc_new;
  end

  // Frame state advances on every accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open  <= 1'b0;
      running_crc <= 16'h0000;
    end else if (in_fire) begin
      frame_open  <= ~in_last;
      running_crc <= in_last ? 16'h0000 : crc_new;
    end
  end

endmodule

`default_nettype wire

### hdl/bsfe_queue.sv
`default_nettype none

module bsfe_queue
  import bsfe_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output cmd_t      head_cmd
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full       = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

### hdl/bsfe_back.sv
`default_nettype none

module bsfe_back
  import bsfe_pkg::*;
#(
  parameter int PREAMBLE_LEN = 8
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       head_valid,
  input  wire cmd_t       head_cmd,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            frame_end,
  output logic            run_last
);

  localparam int CNT_W = $clog2(PREAMBLE_LEN + 1);

  phase_t     phase, phase_next;
  logic       esc, esc_next;
  logic       pre_done, pre_done_next;
  logic [CNT_W-1:0] pre_cnt, pre_cnt_next;

  logic       load;
  logic       go;
  logic       step_pop;
  logic       done;
  logic [7:0] cur_byte;
  stuff_t     st;
  logic [7:0] ob;
  logic       fe;
  logic       rl;

  // The output register takes a new byte when empty or being drained
  assign load = ~out_valid | out_ready;
  assign go   = head_valid & load;
  assign pop  = go & step_pop;

  // Raw byte that the current phase stuffs
  always_comb begin
    unique case (phase)
      ST_DATA:   cur_byte = head_cmd.data;
      ST_CRC_LO: cur_byte = head_cmd.crc[7:0];
      ST_CRC_HI: cur_byte = head_cmd.crc[15:8];
      ST_TRAIL:  cur_byte = TRAIL_BYTE;
      default:   cur_byte = head_cmd.data;
    endcase
  end

  assign st = stuff_byte(cur_byte);

  // Sequencer: one line byte per step
  always_comb begin
    phase_next    = phase;
    esc_next      = esc;
    pre_done_next = pre_done;
    pre_cnt_next  = pre_cnt;
    step_pop      = 1'b0;
    done          = 1'b0;
    ob            = cur_byte;
    fe            = 1'b0;
    rl            = 1'b0;
    if (phase == ST_DATA && head_cmd.preamble && !pre_done) begin
      ob = SYNC_BYTE;
      if (pre_cnt == CNT_W'(PREAMBLE_LEN - 1)) begin
        pre_done_next = 1'b1;
        pre_cnt_next  = '0;
      end else begin
        pre_cnt_next = pre_cnt + 1'b1;
      end
    end else if (phase == ST_TRAIL) begin
      ob            = TRAIL_BYTE;
      fe            = 1'b1;
      rl            = 1'b1;
      step_pop      = 1'b1;
      phase_next    = ST_DATA;
      pre_done_next = 1'b0;
    end else begin
      if (!esc) begin
        ob = st.special ? st.first : cur_byte;
        if (st.special) begin
          esc_next = 1'b1;
        end else begin
          done = 1'b1;
        end
      end else begin
        ob       = st.code;
        esc_next = 1'b0;
        done     = 1'b1;
      end
      if (done) begin
        unique case (phase)
          ST_DATA: begin
            if (head_cmd.last) begin
              phase_next = ST_CRC_LO;
            end else begin
              rl            = 1'b1;
              step_pop      = 1'b1;
              pre_done_next = 1'b0;
            end
          end
          ST_CRC_LO: phase_next = ST_CRC_HI;
          ST_CRC_HI: phase_next = ST_TRAIL;
          default:   phase_next = ST_DATA;
        endcase
      end
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= ST_DATA;
      esc      <= 1'b0;
      pre_done <= 1'b0;
      pre_cnt  <= '0;
    end else if (go) begin
      phase    <= phase_next;
      esc      <= esc_next;
      pre_done <= pre_done_next;
      pre_cnt  <= pre_cnt_next;
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= go;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (go) begin
      out_byte  <= ob;
      frame_end <= fe;
      run_last  <= rl;
    end
  end

endmodule

`default_nettype wire

### hdl/byte_stuffing_frame_encoder.sv
// Byte-stuffing frame encoder with CRC-16/ARC.
// Input stream (s_*): one raw frame byte per beat in s_tdata, s_tlast on the
// final byte of a frame. Output stream (m_*): one line byte per beat, m_tlast
// on the 0x5A trailer, m_tuser on the last line byte caused by an input beat.
// The first byte of a frame is preceded by PREAMBLE_LEN bytes of 0xA5; each
// byte, and the CRC low then high byte after the last one, is escaped if it
// is a sync, trailer or escape code, and the trailer closes the frame.
// The front computes the CRC and classifies each beat in the accept cycle and
// writes a four-entry command queue; the back sequencer reads the queue and
// produces exactly one line byte per cycle into the output register while
// the queue holds a command and the output register is empty or drained.
// With the queue empty, the first line byte of a beat passes the queue
// entry and then the output register before it is presented on m_*. An
// input beat gives one line byte, or two when escaped, plus PREAMBLE_LEN
// sync bytes at frame start and up to five for CRC and trailer at frame end.
// s_tready stays high while the queue has room.
// Reset empties the queue and the output register and closes any open frame.
// When the receiver stalls, the output register holds its beat, the back
// stops, and the queue absorbs up to four more input beats before s_tready
// falls.
`default_nettype none

module byte_stuffing_frame_encoder
  import bsfe_pkg::*;
#(
  parameter int PREAMBLE_LEN = 8
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] data_byte
  input  wire logic       s_tlast,   // last_byte
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] out_byte
  output logic            m_tlast,   // frame_end
  output logic            m_tuser    // [0] run_last
);

  logic in_fire;
  cmd_t front_cmd;
  logic q_full;
  logic q_pop;
  logic q_valid;
  cmd_t q_head;

  assign s_tready = ~q_full;
  assign in_fire  = s_tvalid & s_tready;

  // Front: CRC and classification
  bsfe_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_fire (in_fire),
    .in_data (s_tdata),
    .in_last (s_tlast),
    .cmd     (front_cmd)
  );

  // Command queue
  bsfe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (in_fire),
    .push_cmd   (front_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (q_head)
  );

  // Back: line byte sequencer and output register
  bsfe_back #(
    .PREAMBLE_LEN (PREAMBLE_LEN)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_valid),
    .head_cmd   (q_head),
    .pop        (q_pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_byte   (m_tdata),
    .frame_end  (m_tlast),
    .run_last   (m_tuser)
  );

endmodule

`default_nettype wire

### hdl/bsfe_checker.sv
`default_nettype none

module bsfe_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata,
  input wire logic       m_tlast,
  input wire logic       m_tuser
);

  // Nothing is offered in the cycle after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // The trailer byte, and only the trailer, carries 0x5A
  a_trailer_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata == 8'h5A) == m_tlast))
    else $error("0x5A seen apart from the trailer or trailer with wrong code");

  // The trailer always ends the run of its input beat
  a_trailer_run_end: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> m_tuser)
    else $error("trailer without run end mark");

  // A stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                 && $stable(m_tuser)))
    else $error("output beat changed while stalled");

endmodule

bind byte_stuffing_frame_encoder bsfe_checker u_bsfe_checker (.*);

`default_nettype wire
